// ===== rtl/assert_macros.svh =====
// assertion macros for the rtl files, included by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define SFP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define SFP_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ===== rtl/sfp_pkg.sv =====
// types and constants for the sensor frame parser
`default_nettype none

package sfp_pkg;

   localparam logic [7:0] START_BYTE_A = 8'h42;
   localparam logic [7:0] START_BYTE_B = 8'h4D;
   localparam logic [5:0] LEN_SHORT    = 6'd20;
   localparam logic [5:0] LEN_MID      = 6'd28;
   localparam logic [5:0] LEN_LONG     = 6'd36;
   localparam logic [5:0] POS_HUNT     = 6'd0;
   localparam logic [5:0] POS_START_B  = 6'd1;
   localparam logic [5:0] POS_LEN_HI   = 6'd2;
   localparam logic [5:0] POS_LEN_LO   = 6'd3;
   localparam logic [5:0] POS_PAYLOAD  = 6'd4;

   typedef enum logic [0:0] {
      OP_DATA    = 1'b0,
      OP_RESTART = 1'b1
   } sfp_op_type;

   typedef enum logic [2:0] {
      EV_NONE     = 3'd0,
      EV_PAYLOAD  = 3'd1,
      EV_GOOD     = 3'd2,
      EV_MISMATCH = 3'd3,
      EV_REJECT   = 3'd4
   } sfp_event_type;

   typedef struct packed {
      sfp_event_type event_res;
      logic [7:0]    payload_byte;
      logic [5:0]    payload_pos;
      logic [5:0]    frame_length;
   } sfp_result_type;

endpackage

`default_nettype wire

// ===== rtl/sensor_frame_parser.sv =====
// top level of the byte-serial sensor frame parser
//
//  channel | dir | tdata (low bit up)                       | tuser
//  req_    | in  | rx_byte[7:0]                             | op[0]
//  rsp_    | out | payload_byte, payload_pos, frame_length  | event_res[2:0]
//
// one byte per cycle while req_tready is high: each accepted transfer is
// decoded in the same cycle against the frame state and lands in the result
// register on the next edge; one result transfer for every request transfer
// req_tready stays high while the result register is empty or being drained,
// so a stalled rsp_ side holds one result and backs up the req_ side
// synchronous reset clears the frame state and the result valid flag
`default_nettype none

module sensor_frame_parser (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,  // [7:0] rx_byte
   input  wire logic        req_tuser,  // [0] op
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,  // [7:0] payload_byte, [13:8] payload_pos,
                                        // [19:14] frame_length, [23:20] zero
   output logic [2:0]       rsp_tuser   // [2:0] event_res
);

`include "assert_macros.svh"

   logic                   req_accept;
   sfp_pkg::sfp_result_type core_result;
   sfp_pkg::sfp_result_type result_ff;
   logic                   rsp_valid_ff, rsp_valid_in;

   // result kinds and field checks seen by the assertions
   logic                   rsp_frame_end;
   logic                   rsp_payload;
   logic                   rsp_other;
   logic                   end_len_legal;
   logic                   pos_in_range;
   logic                   payload_clear;

   // the result register frees up in the same cycle it is drained
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   sfp_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (req_accept),
      .op      (req_tuser),
      .rx_byte (req_tdata),
      .result  (core_result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload register, loaded on every accepted transfer
   always_ff @(posedge clock) begin
      if (req_accept) begin
         result_ff <= core_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = result_ff.event_res;
   assign rsp_tdata  = {4'd0, result_ff.frame_length, result_ff.payload_pos,
                        result_ff.payload_byte};

   assign rsp_frame_end = rsp_tvalid && (rsp_tuser == sfp_pkg::EV_GOOD ||
                                         rsp_tuser == sfp_pkg::EV_MISMATCH);
   assign rsp_payload   = rsp_tvalid && (rsp_tuser == sfp_pkg::EV_PAYLOAD);
   assign rsp_other     = rsp_tvalid && (rsp_tuser != sfp_pkg::EV_PAYLOAD);
   assign end_len_legal = (result_ff.frame_length == sfp_pkg::LEN_SHORT) ||
                          (result_ff.frame_length == sfp_pkg::LEN_MID) ||
                          (result_ff.frame_length == sfp_pkg::LEN_LONG);
   assign pos_in_range  = (result_ff.payload_pos <= 6'd33);
   assign payload_clear = (result_ff.payload_byte == 8'd0) &&
                          (result_ff.payload_pos == 6'd0);

   `SFP_ASSERT_ALWAYS(a_no_valid_after_reset, $past(reset) |-> !rsp_tvalid, "valid after reset")
   `SFP_ASSERT(a_accept_gives_result, req_accept |=> rsp_tvalid, "accepted byte gave no result")
   `SFP_ASSERT(a_end_length_legal, rsp_frame_end |-> end_len_legal, "frame end with bad length")
   `SFP_ASSERT(a_payload_pos_range, rsp_payload |-> pos_in_range, "payload position too large")
   `SFP_ASSERT(a_idle_fields_zero, rsp_other |-> payload_clear, "stray payload fields")

endmodule

`default_nettype wire

// ===== rtl/sfp_core.sv =====
// frame state tracking and per-byte result decode
`default_nettype none

module sfp_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire logic               op,
   input  wire logic [7:0]         rx_byte,
   output sfp_pkg::sfp_result_type result
);

   logic [5:0]  byte_position_ff, byte_position_in;
   logic [5:0]  length_field_ff, length_field_in;
   logic [15:0] running_sum_ff, running_sum_in;
   logic [7:0]  received_sum_high_ff, received_sum_high_in;
   logic [7:0]  length_high_byte_ff, length_high_byte_in;

   logic [6:0]  pos_ext;
   logic [6:0]  sum_hi_pos;
   logic [6:0]  sum_lo_pos;
   logic [15:0] sum_plus;
   logic        length_ok;

   assign pos_ext    = {1'b0, byte_position_ff};
   assign sum_hi_pos = {1'b0, length_field_ff} + 7'd2;
   assign sum_lo_pos = {1'b0, length_field_ff} + 7'd3;
   assign sum_plus   = running_sum_ff + {8'd0, rx_byte};
   assign length_ok  = (length_high_byte_ff == 8'd0) &&
                       ((rx_byte == {2'b00, sfp_pkg::LEN_SHORT}) ||
                        (rx_byte == {2'b00, sfp_pkg::LEN_MID}) ||
                        (rx_byte == {2'b00, sfp_pkg::LEN_LONG}));

   always_comb begin
      byte_position_in     = byte_position_ff;
      length_field_in      = length_field_ff;
      running_sum_in       = running_sum_ff;
      received_sum_high_in = received_sum_high_ff;
      length_high_byte_in  = length_high_byte_ff;
      result               = '{sfp_pkg::EV_NONE, 8'd0, 6'd0, 6'd0};

      if (op == sfp_pkg::OP_RESTART) begin
         byte_position_in     = sfp_pkg::POS_HUNT;
         length_field_in      = 6'd0;
         running_sum_in       = 16'd0;
         received_sum_high_in = 8'd0;
         length_high_byte_in  = 8'd0;
      end else if (byte_position_ff == sfp_pkg::POS_HUNT) begin
         if (rx_byte == sfp_pkg::START_BYTE_A) begin
            running_sum_in   = {8'd0, rx_byte};
            byte_position_in = sfp_pkg::POS_START_B;
         end
      end else if (byte_position_ff == sfp_pkg::POS_START_B) begin
         if (rx_byte != sfp_pkg::START_BYTE_B) begin
            byte_position_in = sfp_pkg::POS_HUNT;
            result.event_res = sfp_pkg::EV_REJECT;
         end else begin
            running_sum_in   = sum_plus;
            byte_position_in = sfp_pkg::POS_LEN_HI;
         end
      end else if (byte_position_ff == sfp_pkg::POS_LEN_HI) begin
         running_sum_in      = sum_plus;
         length_high_byte_in = rx_byte;
         byte_position_in    = sfp_pkg::POS_LEN_LO;
      end else if (byte_position_ff == sfp_pkg::POS_LEN_LO) begin
         if (!length_ok) begin
            byte_position_in = sfp_pkg::POS_HUNT;
            result.event_res = sfp_pkg::EV_REJECT;
         end else begin
            length_field_in  = rx_byte[5:0];
            running_sum_in   = sum_plus;
            byte_position_in = sfp_pkg::POS_PAYLOAD;
         end
      end else if (pos_ext == sum_hi_pos) begin
         received_sum_high_in = rx_byte;
         byte_position_in     = byte_position_ff + 6'd1;
      end else if (pos_ext == sum_lo_pos) begin
         result.event_res    = ({received_sum_high_ff, rx_byte} == running_sum_ff) ?
                               sfp_pkg::EV_GOOD : sfp_pkg::EV_MISMATCH;
         result.frame_length = length_field_ff;
         byte_position_in    = sfp_pkg::POS_HUNT;
      end else begin
         running_sum_in      = sum_plus;
         result.event_res    = sfp_pkg::EV_PAYLOAD;
         result.payload_byte = rx_byte;
         result.payload_pos  = byte_position_ff - sfp_pkg::POS_PAYLOAD;
         byte_position_in    = byte_position_ff + 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff     <= sfp_pkg::POS_HUNT;
         length_field_ff      <= 6'd0;
         running_sum_ff       <= 16'd0;
         received_sum_high_ff <= 8'd0;
         length_high_byte_ff  <= 8'd0;
      end else if (advance) begin
         byte_position_ff     <= byte_position_in;
         length_field_ff      <= length_field_in;
         running_sum_ff       <= running_sum_in;
         received_sum_high_ff <= received_sum_high_in;
         length_high_byte_ff  <= length_high_byte_in;
      end
   end

endmodule

`default_nettype wire

// ===== dv/sfp_frame_checker.sv =====
// frame parser scoreboard: predicts each result from the request transfers and checks the responses
module sfp_frame_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   input  logic [2:0]  rsp_tuser,
   output int          mismatches,
   output int          outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   // parser state as the block should hold it
   logic [5:0]  frame_pos;
   logic [5:0]  accepted_len;
   logic [15:0] frame_sum;
   logic [7:0]  sum_high;
   logic [7:0]  len_high;

   sfp_pkg::sfp_result_type parsed_q[$];

   function automatic void clear_parser();
      frame_pos    = sfp_pkg::POS_HUNT;
      accepted_len = '0;
      frame_sum    = '0;
      sum_high     = '0;
      len_high     = '0;
   endfunction

   function automatic sfp_pkg::sfp_result_type parse_byte(sfp_pkg::sfp_op_type op,
                                                          logic [7:0] rx);
      sfp_pkg::sfp_result_type res;
      res = '0;
      res.event_res = sfp_pkg::EV_NONE;
      if (op == sfp_pkg::OP_RESTART) begin
         clear_parser();
      end else if (frame_pos == sfp_pkg::POS_HUNT) begin
         if (rx == sfp_pkg::START_BYTE_A) begin
            frame_sum = {8'h00, rx};
            frame_pos = sfp_pkg::POS_START_B;
         end
      end else if (frame_pos == sfp_pkg::POS_START_B) begin
         // a wrong second byte is dropped, never taken as a fresh start byte
         if (rx != sfp_pkg::START_BYTE_B) begin
            frame_pos = sfp_pkg::POS_HUNT;
            res.event_res = sfp_pkg::EV_REJECT;
         end else begin
            frame_sum = frame_sum + {8'h00, rx};
            frame_pos = sfp_pkg::POS_LEN_HI;
         end
      end else if (frame_pos == sfp_pkg::POS_LEN_HI) begin
         frame_sum = frame_sum + {8'h00, rx};
         len_high  = rx;
         frame_pos = sfp_pkg::POS_LEN_LO;
      end else if (frame_pos == sfp_pkg::POS_LEN_LO) begin
         if (len_high != 8'h00 ||
             !(rx == {2'b00, sfp_pkg::LEN_SHORT} || rx == {2'b00, sfp_pkg::LEN_MID} ||
               rx == {2'b00, sfp_pkg::LEN_LONG})) begin
            frame_pos = sfp_pkg::POS_HUNT;
            res.event_res = sfp_pkg::EV_REJECT;
         end else begin
            accepted_len = rx[5:0];
            frame_sum    = frame_sum + {8'h00, rx};
            frame_pos    = sfp_pkg::POS_PAYLOAD;
         end
      end else if (frame_pos == accepted_len + 6'd2) begin
         sum_high  = rx;
         frame_pos = frame_pos + 6'd1;
      end else if (frame_pos == accepted_len + 6'd3) begin
         res.event_res    = ({sum_high, rx} == frame_sum) ? sfp_pkg::EV_GOOD
                                                          : sfp_pkg::EV_MISMATCH;
         res.frame_length = accepted_len;
         frame_pos        = sfp_pkg::POS_HUNT;
      end else begin
         frame_sum        = frame_sum + {8'h00, rx};
         res.event_res    = sfp_pkg::EV_PAYLOAD;
         res.payload_byte = rx;
         res.payload_pos  = frame_pos - sfp_pkg::POS_PAYLOAD;
         frame_pos        = frame_pos + 6'd1;
      end
      return res;
   endfunction

   initial begin
      mismatches  = 0;
      outstanding = 0;
      clear_parser();
   end

   always @(posedge clock) begin
      sfp_pkg::sfp_result_type exp_res;
      if (reset) begin
         clear_parser();
         parsed_q.delete();
      end else begin
         if (req_tvalid && req_tready)
            parsed_q.push_back(parse_byte(sfp_pkg::sfp_op_type'(req_tuser), req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (parsed_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result at %0t: ev=%0d tdata=%06h",
                           $realtime, rsp_tuser, rsp_tdata);
            end else begin
               exp_res = parsed_q.pop_front();
               if (rsp_tuser != exp_res.event_res ||
                   rsp_tdata[7:0] != exp_res.payload_byte ||
                   rsp_tdata[13:8] != exp_res.payload_pos ||
                   rsp_tdata[19:14] != exp_res.frame_length ||
                   rsp_tdata[23:20] != 4'h0) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch at %0t: expected ev=%0d byte=%02h pos=%0d len=%0d,",
                               " got ev=%0d byte=%02h pos=%0d len=%0d pad=%h"},
                              $realtime, exp_res.event_res, exp_res.payload_byte,
                              exp_res.payload_pos, exp_res.frame_length,
                              rsp_tuser, rsp_tdata[7:0], rsp_tdata[13:8],
                              rsp_tdata[19:14], rsp_tdata[23:20]);
               end
            end
         end
      end
      outstanding = parsed_q.size();
   end

endmodule

// ===== dv/sensor_frame_parser_tb.sv =====
// top of the frame parser testbench: clock, reset, byte stimulus, response stalls and verdict
module sensor_frame_parser_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEM_TARGET = 700;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] rx_byte
   logic        req_tuser;   // [0] op
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // [7:0] payload_byte, [13:8] payload_pos, [19:14] frame_length
   logic [2:0]  rsp_tuser;   // [2:0] event_res

   int mismatches;
   int outstanding;

   // idle percentages for each side, changed by the stimulus phases
   int req_idle_pct = 27;
   int rsp_idle_pct = 27;
   // request for a long receiver hold-off, picked up by the receiver process
   bit hold_start   = 1'b0;
   bit hold_done    = 1'b0;
   int hold_left    = 0;
   int sent_items   = 0;

   sensor_frame_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   sfp_frame_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // hard stop in case the handshakes lock up
   initial begin
      #1_000_000;
      $display("FAILURE");
      $finish;
   end

   // offer one byte, with random idle cycles ahead of it, and hold it until the transfer
   // tready is sampled straight after the edge, before any register update of that edge
   task automatic send_byte(sfp_pkg::sfp_op_type op, logic [7:0] rx);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= rx;
      req_tuser  <= op;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      sent_items++;
   endtask

   // mostly random payload bytes, with the extremes now and then
   function automatic logic [7:0] payload_value();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [7:0] pick_length();
      case ($urandom_range(0, 2))
         0:       return {2'b00, sfp_pkg::LEN_SHORT};
         1:       return {2'b00, sfp_pkg::LEN_MID};
         default: return {2'b00, sfp_pkg::LEN_LONG};
      endcase
   endfunction

   // whole frame: header, payload, sum16 checksum; the checksum may be spoilt and a
   // restart may cut the frame short at byte cut_at (negative for none)
   task automatic send_frame(logic [7:0] len, bit spoil, int cut_at);
      logic [7:0]  frame[$];
      logic [15:0] csum;
      frame = '{sfp_pkg::START_BYTE_A, sfp_pkg::START_BYTE_B, 8'h00, len};
      for (int i = 0; i < len - 2; i++)
         frame.push_back(payload_value());
      csum = '0;
      foreach (frame[i])
         csum = csum + {8'h00, frame[i]};
      if (spoil)
         csum = csum ^ 16'($urandom_range(1, 65535));
      frame.push_back(csum[15:8]);
      frame.push_back(csum[7:0]);
      foreach (frame[i]) begin
         if (i == cut_at) begin
            send_byte(sfp_pkg::OP_RESTART, 8'($urandom_range(0, 255)));
            return;
         end
         send_byte(sfp_pkg::OP_DATA, frame[i]);
      end
   endtask

   // broken or partial sequences and stray bytes
   task automatic send_noise();
      case ($urandom_range(0, 5))
         0: send_byte(sfp_pkg::OP_DATA, 8'($urandom_range(0, 255)));
         1: begin
            send_byte(sfp_pkg::OP_DATA, sfp_pkg::START_BYTE_A);
            send_byte(sfp_pkg::OP_DATA, 8'($urandom_range(0, 255)));
         end
         2: begin
            // header with a length that is mostly wrong
            send_byte(sfp_pkg::OP_DATA, sfp_pkg::START_BYTE_A);
            send_byte(sfp_pkg::OP_DATA, sfp_pkg::START_BYTE_B);
            send_byte(sfp_pkg::OP_DATA, ($urandom_range(0, 1) != 0) ? 8'h00
                                                  : 8'($urandom_range(0, 255)));
            send_byte(sfp_pkg::OP_DATA, ($urandom_range(0, 3) == 0) ? pick_length()
                                                  : 8'($urandom_range(0, 255)));
         end
         3: send_byte(sfp_pkg::OP_RESTART, 8'($urandom_range(0, 255)));
         4: send_byte(sfp_pkg::OP_DATA, sfp_pkg::START_BYTE_B);
         default: begin
            send_byte(sfp_pkg::OP_DATA, sfp_pkg::START_BYTE_A);
            send_byte(sfp_pkg::OP_DATA, sfp_pkg::START_BYTE_B);
         end
      endcase
   endtask

   // receiver: random stalls, or a long hold-off when asked for one
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_start) begin
            hold_start = 1'b0;
            hold_left  = 80;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= rsp_idle_pct);
         end
      end
   end

   // stimulus and verdict
   initial begin
      int drain_wait;
      req_tvalid <= 1'b0;
      req_tdata  <= 8'h00;
      req_tuser  <= sfp_pkg::OP_DATA;
      reset      <= 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: restart, stray bytes while hunting
      send_byte(sfp_pkg::OP_RESTART, 8'hFF);
      send_byte(sfp_pkg::OP_DATA, 8'h00);
      send_byte(sfp_pkg::OP_DATA, 8'hFF);
      // wrong second byte that is itself a start byte, then a lone second start byte
      send_byte(sfp_pkg::OP_DATA, sfp_pkg::START_BYTE_A);
      send_byte(sfp_pkg::OP_DATA, sfp_pkg::START_BYTE_A);
      send_byte(sfp_pkg::OP_DATA, sfp_pkg::START_BYTE_B);
      // nonzero length high byte with a good low byte
      send_byte(sfp_pkg::OP_DATA, sfp_pkg::START_BYTE_A);
      send_byte(sfp_pkg::OP_DATA, sfp_pkg::START_BYTE_B);
      send_byte(sfp_pkg::OP_DATA, 8'h01);
      send_byte(sfp_pkg::OP_DATA, {2'b00, sfp_pkg::LEN_SHORT});
      // length not in the allowed set
      send_byte(sfp_pkg::OP_DATA, sfp_pkg::START_BYTE_A);
      send_byte(sfp_pkg::OP_DATA, sfp_pkg::START_BYTE_B);
      send_byte(sfp_pkg::OP_DATA, 8'h00);
      send_byte(sfp_pkg::OP_DATA, 8'd21);
      // longest frame cut by a restart in the payload
      send_byte(sfp_pkg::OP_DATA, sfp_pkg::START_BYTE_A);
      send_byte(sfp_pkg::OP_DATA, sfp_pkg::START_BYTE_B);
      send_byte(sfp_pkg::OP_DATA, 8'h00);
      send_byte(sfp_pkg::OP_DATA, {2'b00, sfp_pkg::LEN_LONG});
      send_byte(sfp_pkg::OP_DATA, 8'h00);
      send_byte(sfp_pkg::OP_DATA, 8'hFF);
      send_byte(sfp_pkg::OP_RESTART, 8'h00);

      // one good and one bad checksum before the random mix
      send_frame({2'b00, sfp_pkg::LEN_SHORT}, 1'b0, -1);
      send_frame({2'b00, sfp_pkg::LEN_LONG}, 1'b1, -1);

      while (sent_items < ITEM_TARGET) begin
         // quiet stretch with no idling on either side
         if (sent_items >= 300 && sent_items < 450) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end else begin
            req_idle_pct = 27;
            rsp_idle_pct = 27;
         end
         // long receiver hold-off while bytes keep coming
         if (!hold_done && sent_items >= 150) begin
            hold_done  = 1'b1;
            hold_start = 1'b1;
         end
         if ($urandom_range(0, 99) < 75)
            send_frame(pick_length(), $urandom_range(0, 99) < 30,
                       ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 39)) : -1);
         else
            send_noise();
      end
      req_tvalid <= 1'b0;

      // let the last results drain, then watch for anything stray before the verdict
      drain_wait = 0;
      while (outstanding != 0 && drain_wait < 2000) begin
         @(posedge clock);
         drain_wait++;
      end
      repeat (5) @(posedge clock);

      if (mismatches == 0 && outstanding == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
